// ----- hw/rtl/pidaw_pkg.sv -----
// pidaw_pkg: shared types, codes and saturation helpers for the pid block
// no dependencies; compiled first, used by the channel interfaces and the top level
package pidaw_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned LIM_W      = 31;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [64:0] Q_MAX65 = 65'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [64:0] Q_MIN65 = 65'sh1_FFFF_FFFF_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_OUTPUT_LIMIT   = 3'd4,
    CFG_FILTER_ALPHA   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ACT_COMPUTE = 1'b0,
    ACT_CLEAR   = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    SAT_NONE = 2'd0,
    SAT_HIGH = 2'd1,
    SAT_LOW  = 2'd2
  } sat_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERRDT,
    ST_INTEG,
    ST_PMUL,
    ST_PACC,
    ST_IACC,
    ST_DWAIT,
    ST_AMUL,
    ST_AACC,
    ST_BMUL,
    ST_FILT,
    ST_DMUL,
    ST_DACC,
    ST_FINAL,
    ST_OUT
  } state_e;

  // sign extend a q16.16 value to the working width
  function automatic logic signed [64:0] wide(input logic signed [31:0] v);
    return {{33{v[31]}}, v};
  endfunction

  // clip to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > Q_MAX65) begin
      return Q_MAX;
    end else if (v < Q_MIN65) begin
      return Q_MIN;
    end else begin
      return v[31:0];
    end
  endfunction

  // floor divide by 2^16, then clip
  function automatic logic signed [31:0] floor_q16(input logic signed [64:0] v);
    return sat32(v >>> 16);
  endfunction

endpackage

// ----- hw/rtl/pidaw_req_if.sv -----
// pidaw_req_if: request channel of the pid block (valid/ready plus payload)
// depends on pidaw_pkg for field widths
interface pidaw_req_if import pidaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measurement;
  logic [DT_W-1:0]          time_step;

  modport source (output valid, action, setpoint, measurement, time_step, input ready);
  modport sink   (input valid, action, setpoint, measurement, time_step, output ready);
endinterface

// ----- hw/rtl/pidaw_rsp_if.sv -----
// pidaw_rsp_if: result channel of the pid block (valid/ready plus payload)
// depends on pidaw_pkg for field widths
interface pidaw_rsp_if import pidaw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic [1:0]               saturation;

  modport source (output valid, drive, saturation, input ready);
  modport sink   (input valid, drive, saturation, output ready);
endinterface

// ----- hw/rtl/pid_antiwindup_filtered_derivative.sv -----
// pid_antiwindup_filtered_derivative: fixed point pid step with integral clamp,
// filtered derivative on measurement and back-calculation anti-windup
// depends on pidaw_pkg, pidaw_req_if and pidaw_rsp_if
//
// usage
// - req_i carries one request: action (compute or clear), setpoint, measurement
//   and time_step; setpoint and measurement are q16.16, time_step is unsigned q0.16 seconds
// - rsp_o returns exactly one result per request: drive and saturation code
// - cfg_we_i / cfg_idx_i / cfg_data_i write the gains, limits and filter weight;
//   write only while no request is in flight, unknown indexes are dropped
// - one request at a time: req_i.ready is high only while the block is idle
// - a clear request or a zero time_step answers zero, going from the accept straight to the result state
// - a compute request runs from ST_ERRDT to ST_FINAL; the 48-bit serial
//   divider for the measurement rate (2 quotient bits per cycle) can hold
//   it in ST_DWAIT, and the six products go through one shared 33x32 multiplier,
//   partly hidden behind the divider
// - on the first step after reset or clear no division runs and the raw rate is zero
// - the next request is taken the cycle after the result leaves at the earliest
// - the result sits in an output register until rsp_o.ready; a stalled
//   receiver simply holds the block in its result state, nothing is lost
// - reset restores the register defaults and clears the controller state
//   (integral, last measurement, filtered rate, first-step flag)
module pid_antiwindup_filtered_derivative import pidaw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pidaw_req_if.sink             req_i,
  pidaw_rsp_if.source           rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DIV_N_W   = DATA_W + 16;  // numerator is |diff| * 2^16
  localparam int unsigned DIV_STEPS = DIV_N_W / 2;  // two quotient bits per cycle
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // configuration registers
  logic [31:0]        gain_p_q, gain_i_q, gain_d_q;
  logic [LIM_W-1:0]   ilim_q, olim_q;
  logic [ALPHA_W-1:0] alpha_q;

  // controller state
  logic signed [31:0] integ_q, last_q, filt_q;
  logic               first_q;

  // per-request working registers
  logic signed [31:0] err_q, errdt_q, meas_q, drive_q;
  logic signed [33:0] sum_q;
  logic signed [48:0] facc_q;
  sat_e               sat_q;

  // shared multiplier
  logic signed [32:0] op_a_q;
  logic signed [31:0] op_b_q;
  logic signed [64:0] prod_q;

  // serial divider
  logic                 div_busy_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DIV_N_W-1:0]   div_nq_q;
  logic [DT_W-1:0]      div_rem_q;
  logic [DT_W-1:0]      dt_q;
  logic                 div_neg_q;

  state_e state_q, state_d;

  logic               in_acc;
  logic               quick;
  logic signed [31:0] err_in, diff_in;
  logic [31:0]        diff_mag;
  logic [ALPHA_W-1:0] alpha_eff;
  logic signed [31:0] prod_fl;
  logic signed [31:0] integ_new;
  logic signed [31:0] ilim_s, olim_s;
  logic signed [33:0] term_add;
  logic signed [48:0] fsum;
  logic signed [31:0] filt_new;
  logic signed [31:0] raw;
  logic signed [31:0] drive_sum;
  logic [DT_W:0]      r1, r2;
  logic               ge1, ge2;
  logic [DT_W-1:0]    r1n, r2n;
  logic [DIV_N_W-1:0] nq1, nq2;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= 32'h0001_0000;
      gain_i_q <= '0;
      gain_d_q <= '0;
      ilim_q   <= '1;
      olim_q   <= '1;
      alpha_q  <= ONE_Q16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_P:         gain_p_q <= cfg_data_i;
        CFG_GAIN_I:         gain_i_q <= cfg_data_i;
        CFG_GAIN_D:         gain_d_q <= cfg_data_i;
        CFG_INTEGRAL_LIMIT: ilim_q   <= cfg_data_i[LIM_W-1:0];
        CFG_OUTPUT_LIMIT:   olim_q   <= cfg_data_i[LIM_W-1:0];
        CFG_FILTER_ALPHA:   alpha_q  <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  assign in_acc  = req_i.valid && req_i.ready;
  // clear or invalid dt skips the computation and answers zero
  assign quick   = (req_i.action == ACT_CLEAR) || (req_i.time_step == '0);

  assign err_in   = sat32(wide(req_i.setpoint) - wide(req_i.measurement));
  assign diff_in  = sat32(wide(last_q) - wide(req_i.measurement));
  // two's complement magnitude; the most negative value maps to 2^31
  assign diff_mag = diff_in[31] ? 32'(-diff_in) : diff_in;

  assign alpha_eff = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
  assign ilim_s    = $signed({1'b0, ilim_q});
  assign olim_s    = $signed({1'b0, olim_q});

  assign prod_fl = floor_q16(prod_q);

  // integral update with clamp to +-limit
  always_comb begin
    integ_new = sat32(wide(integ_q) + wide(prod_fl));
    if (integ_new > ilim_s) begin
      integ_new = ilim_s;
    end else if (integ_new < -ilim_s) begin
      integ_new = -ilim_s;
    end
  end

  assign term_add = sum_q + {{2{prod_fl[31]}}, prod_fl};
  assign fsum     = facc_q + $signed(prod_q[48:0]);
  assign filt_new = floor_q16({{16{fsum[48]}}, fsum});
  assign drive_sum = sat32({{31{sum_q[33]}}, sum_q});

  // truncated quotient back to signed, clipped to 32 bits; zero on a first step
  always_comb begin
    if (first_q) begin
      raw = '0;
    end else if (div_neg_q) begin
      raw = (div_nq_q > DIV_N_W'(33'h0_8000_0000)) ? Q_MIN : 32'(-div_nq_q[31:0]);
    end else begin
      raw = (div_nq_q > DIV_N_W'(32'h7FFF_FFFF)) ? Q_MAX : div_nq_q[31:0];
    end
  end

  // two restoring steps per cycle; remainder stays below dt
  always_comb begin
    r1  = {div_rem_q, div_nq_q[DIV_N_W-1]};
    ge1 = r1 >= {1'b0, dt_q};
    r1n = ge1 ? DT_W'(r1 - {1'b0, dt_q}) : r1[DT_W-1:0];
    nq1 = {div_nq_q[DIV_N_W-2:0], ge1};
    r2  = {r1n, nq1[DIV_N_W-1]};
    ge2 = r2 >= {1'b0, dt_q};
    r2n = ge2 ? DT_W'(r2 - {1'b0, dt_q}) : r2[DT_W-1:0];
    nq2 = {nq1[DIV_N_W-2:0], ge2};
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = quick ? ST_OUT : ST_ERRDT;
      ST_ERRDT: state_d = ST_INTEG;
      ST_INTEG: state_d = ST_PMUL;
      ST_PMUL:  state_d = ST_PACC;
      ST_PACC:  state_d = ST_IACC;
      ST_IACC:  state_d = ST_DWAIT;
      ST_DWAIT: if (!div_busy_q) state_d = ST_AMUL;
      ST_AMUL:  state_d = ST_AACC;
      ST_AACC:  state_d = ST_BMUL;
      ST_BMUL:  state_d = ST_FILT;
      ST_FILT:  state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_DACC;
      ST_DACC:  state_d = ST_FINAL;
      ST_FINAL: state_d = ST_OUT;
      ST_OUT:   if (rsp_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = (state_q == ST_OUT);
  assign rsp_o.drive      = drive_q;
  assign rsp_o.saturation = sat_q;

  // ---------------------------------------------------------------------------
  // shared multiplier: product registered every cycle from registered operands
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_q * op_b_q;
  end

  // ---------------------------------------------------------------------------
  // controller state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
      filt_q  <= '0;
      first_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && req_i.action == ACT_CLEAR) begin
            integ_q <= '0;
            last_q  <= '0;
            filt_q  <= '0;
            first_q <= 1'b1;
          end
        end
        ST_INTEG: integ_q <= integ_new;
        ST_FILT:  filt_q  <= filt_new;
        ST_FINAL: begin
          last_q  <= meas_q;
          first_q <= 1'b0;
          // back-calculation: undo this step's integration when it drives
          // further into the clip
          if (drive_sum > olim_s && err_q > 0) begin
            integ_q <= sat32(wide(integ_q) - wide(errdt_q));
          end else if (drive_sum < -olim_s && err_q < 0) begin
            integ_q <= sat32(wide(integ_q) - wide(errdt_q));
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // working registers and operand steering
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          err_q   <= err_in;
          meas_q  <= req_i.measurement;
          op_a_q  <= {err_in[31], err_in};
          op_b_q  <= {16'b0, req_i.time_step};
          drive_q <= '0;
          sat_q   <= SAT_NONE;
        end
      end
      ST_INTEG: begin
        errdt_q <= prod_fl;
        op_a_q  <= {1'b0, gain_p_q};
        op_b_q  <= err_q;
      end
      ST_PMUL: begin
        op_a_q <= {1'b0, gain_i_q};
        op_b_q <= integ_q;
      end
      ST_PACC:  sum_q <= {{2{prod_fl[31]}}, prod_fl};
      ST_IACC:  sum_q <= term_add;
      ST_DWAIT: begin
        op_a_q <= {16'b0, alpha_eff};
        op_b_q <= raw;
      end
      ST_AACC: begin
        facc_q <= $signed(prod_q[48:0]);
        op_a_q <= {16'b0, ALPHA_W'(ONE_Q16 - alpha_eff)};
        op_b_q <= filt_q;
      end
      ST_FILT: begin
        op_a_q <= {1'b0, gain_d_q};
        op_b_q <= filt_new;
      end
      ST_DACC:  sum_q <= term_add;
      ST_FINAL: begin
        if (drive_sum > olim_s) begin
          drive_q <= olim_s;
          sat_q   <= SAT_HIGH;
        end else if (drive_sum < -olim_s) begin
          drive_q <= -olim_s;
          sat_q   <= SAT_LOW;
        end else begin
          drive_q <= drive_sum;
          sat_q   <= SAT_NONE;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // serial divider: |diff| * 2^16 / dt, runs beside the first products
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (in_acc && !quick && !first_q) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 1'b1;
      if (div_cnt_q == DIV_LAST) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !quick && !first_q) begin
      div_nq_q  <= {diff_mag, 16'b0};
      div_rem_q <= '0;
      div_neg_q <= diff_in[31];
      dt_q      <= req_i.time_step;
    end else if (div_busy_q) begin
      div_nq_q  <= nq2;
      div_rem_q <= r2n;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while a result is pending");

  a_quick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && quick) |=> (rsp_o.valid && rsp_o.drive == '0 && rsp_o.saturation == SAT_NONE))
    else $error("clear or zero dt did not answer zero next cycle");

  a_clip_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.saturation == SAT_HIGH) |-> (rsp_o.drive == olim_s))
    else $error("clipped high result differs from output limit");

  a_clip_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.saturation == SAT_LOW) |-> (rsp_o.drive == -olim_s))
    else $error("clipped low result differs from negated output limit");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DWAIT && state_d == ST_AMUL) |-> !div_busy_q)
    else $error("rate used before divider finished");

endmodule

// ----- dv/testbench.sv -----
// testbench: self-checking regression for the pid step with integral clamp,
// filtered derivative and anti-windup; drives requests, predicts each drive and checks it
// depends on pidaw_pkg, pidaw_req_if, pidaw_rsp_if and the rtl top level only
`timescale 1ns / 1ps

module testbench;
  import pidaw_pkg::*;

  localparam longint      S32_HI          = 64'sd2147483647;
  localparam longint      S32_LO          = -64'sd2147483648;
  localparam longint      UNITY           = 65536;
  localparam logic [15:0] DT_MAX          = 16'hFFFF;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
  // indexes outside the register map, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned STALL_CYCLES    = 400;
  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned ITEMS_PER_PHASE = 162;
  localparam int unsigned MAX_PRINTS      = 100;

  typedef struct packed {
    logic signed [31:0] drive;
    sat_e               sat;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pidaw_req_if req_bus ();
  pidaw_rsp_if rsp_bus ();

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pid_antiwindup_filtered_derivative dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the register file, reset values
  logic [31:0] k_p            = 32'h0001_0000;
  logic [31:0] k_i            = 32'h0;
  logic [31:0] k_d            = 32'h0;
  logic [30:0] clamp_integral = 31'h7FFF_FFFF;
  logic [30:0] clamp_drive    = 31'h7FFF_FFFF;
  logic [16:0] alpha_reg      = 17'h1_0000;

  // shadow controller state, reset values
  logic signed [31:0] acc_integral  = '0;
  logic signed [31:0] prev_measure  = '0;
  logic signed [31:0] rate_filtered = '0;
  bit                 fresh_run     = 1'b1;

  drive_result_t pending_drives[$];
  drive_result_t want;

  // stimulus knobs shared by the sender and the result taker
  bit          bubbles_on    = 1'b1;
  int unsigned rx_hold_cycles = 0;

  int unsigned err_cnt      = 0;
  int unsigned n_sent       = 0;
  int unsigned n_clears     = 0;
  int unsigned n_zero_dt    = 0;
  int unsigned n_settings   = 0;
  int unsigned n_checked    = 0;
  int unsigned n_clip_high  = 0;
  int unsigned n_clip_low   = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] clip_s32(longint v);
    if (v > S32_HI) return Q_MAX;
    if (v < S32_LO) return Q_MIN;
    return v[31:0];
  endfunction

  // gain (unsigned q16.16) times value, floored back to q16.16
  function automatic logic signed [31:0] scale_q16(logic [31:0] gain, logic signed [31:0] x);
    return clip_s32((longint'(gain) * longint'(x)) >>> 16);
  endfunction

  function automatic void note_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      CFG_GAIN_P:         k_p = data;
      CFG_GAIN_I:         k_i = data;
      CFG_GAIN_D:         k_d = data;
      CFG_INTEGRAL_LIMIT: clamp_integral = data[30:0];
      CFG_OUTPUT_LIMIT:   clamp_drive = data[30:0];
      CFG_FILTER_ALPHA:   alpha_reg = data[16:0];
      default: ;
    endcase
  endfunction

  // one controller step: updates the shadow state, returns the expected result
  function automatic drive_result_t predict_drive(act_e act, logic signed [31:0] setpt,
                                                  logic signed [31:0] meas,
                                                  logic [15:0] time_step);
    drive_result_t      r;
    longint             ilim, olim, wgt, sum, raw;
    logic signed [31:0] err, err_dt, diff;
    r.drive = '0;
    r.sat   = SAT_NONE;
    if (act == ACT_CLEAR) begin
      acc_integral  = '0;
      prev_measure  = '0;
      rate_filtered = '0;
      fresh_run     = 1'b1;
      return r;
    end
    // invalid time step: zero drive, state untouched
    if (time_step == '0) return r;

    ilim = longint'(clamp_integral);
    olim = longint'(clamp_drive);
    wgt  = (alpha_reg > UNITY) ? UNITY : longint'(alpha_reg);

    err    = clip_s32(longint'(setpt) - longint'(meas));
    err_dt = clip_s32((longint'(err) * longint'(time_step)) >>> 16);

    sum = longint'(clip_s32(longint'(acc_integral) + longint'(err_dt)));
    if (sum > ilim) sum = ilim;
    if (sum < -ilim) sum = -ilim;
    acc_integral = sum[31:0];

    // derivative on the negated measurement change, none on the first step
    raw = 0;
    if (!fresh_run) begin
      diff = clip_s32(longint'(prev_measure) - longint'(meas));
      raw  = longint'(clip_s32((longint'(diff) * UNITY) / longint'(time_step)));
    end
    rate_filtered = clip_s32((wgt * raw + (UNITY - wgt) * longint'(rate_filtered)) >>> 16);
    prev_measure  = meas;
    fresh_run     = 1'b0;

    sum = longint'(scale_q16(k_p, err)) + longint'(scale_q16(k_i, acc_integral))
        + longint'(scale_q16(k_d, rate_filtered));
    r.drive = clip_s32(sum);

    // output clip with back-calculation when the error pushes further out
    if (longint'(r.drive) > olim) begin
      r.drive = olim[31:0];
      r.sat   = SAT_HIGH;
      if (err > 0) acc_integral = clip_s32(longint'(acc_integral) - longint'(err_dt));
    end else if (longint'(r.drive) < -olim) begin
      r.drive = 32'(-olim);
      r.sat   = SAT_LOW;
      if (err < 0) acc_integral = clip_s32(longint'(acc_integral) - longint'(err_dt));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, often a short bubble, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 48);
  endfunction

  function automatic logic signed [31:0] rand_span(int unsigned mag);
    return clip_s32(longint'($urandom_range(0, 2 * mag)) - longint'(mag));
  endfunction

  task automatic report_mismatch(string msg);
    // keep the log readable when the design is badly off
    if (err_cnt < MAX_PRINTS) $display("mismatch @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // offer one request; valid stays high afterwards unless a bubble follows
  task automatic send_request(act_e act, logic signed [31:0] setpt,
                              logic signed [31:0] meas, logic [15:0] time_step);
    int unsigned gap;
    gap = bubbles_on ? pick_gap() : 0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.action      <= act;
    req_bus.setpoint    <= setpt;
    req_bus.measurement <= meas;
    req_bus.time_step   <= time_step;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    pending_drives.push_back(predict_drive(act, setpt, meas, time_step));
    n_sent++;
    if (act == ACT_CLEAR) n_clears++;
    else if (time_step == '0) n_zero_dt++;
  endtask

  // drop valid, let every outstanding request come back, then a short pause
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // the write enable stays high across consecutive writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    note_reg(idx, data);
  endtask

  task automatic release_cfg();
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_settings(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                               logic [31:0] ilim, logic [31:0] olim, logic [31:0] alpha);
    write_reg(CFG_GAIN_P, p);
    write_reg(CFG_GAIN_I, i);
    write_reg(CFG_GAIN_D, d);
    write_reg(CFG_INTEGRAL_LIMIT, ilim);
    write_reg(CFG_OUTPUT_LIMIT, olim);
    write_reg(CFG_FILTER_ALPHA, alpha);
    release_cfg();
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: unit proportional gain only, limits wide open
  task automatic test_field_extremes();
    send_request(ACT_COMPUTE, Q_MAX, Q_MIN, DT_MAX);      // error saturates high
    send_request(ACT_COMPUTE, Q_MIN, Q_MAX, 16'd1);       // saturates low, clipped low
    send_request(ACT_COMPUTE, 32'sd0, 32'sd0, 16'd0);     // zero time step
    send_request(ACT_COMPUTE, 32'sh0001_0000, -32'sh0001_0000, DT_MAX);
    send_request(ACT_CLEAR, Q_MAX, Q_MIN, DT_MAX);
    send_request(ACT_CLEAR, Q_MIN, Q_MAX, 16'd0);
    send_request(ACT_COMPUTE, -32'sd1, 32'sd1, 16'd1);
    send_request(ACT_COMPUTE, Q_MAX, Q_MAX, DT_MAX);
  endtask

  // tight limits so the integral clamps and the output clips both ways
  task automatic test_integral_windup();
    wait_idle();
    load_settings(32'h0000_8000, 32'h0002_0000, 32'h0, 32'h0003_0000, 32'h0002_0000,
                  32'(UNITY));
    send_request(ACT_COMPUTE, 32'sh000A_0000, 32'sd0, 16'h8000);
    send_request(ACT_COMPUTE, 32'sh000A_0000, 32'sd0, 16'h8000);
    send_request(ACT_COMPUTE, -32'sh000A_0000, 32'sd0, 16'h8000);
    send_request(ACT_COMPUTE, -32'sh000A_0000, 32'sd0, 16'h8000);
    send_request(ACT_COMPUTE, 32'sh0000_4000, 32'sd0, 16'h1000);
    send_request(ACT_COMPUTE, 32'sd0, 32'sh0000_1000, DT_MAX);
  endtask

  // derivative only: first step, rises, drops, zero dt, alpha above one and zero
  task automatic test_derivative_filter();
    wait_idle();
    load_settings(32'h0, 32'h0, 32'h0001_0000, ALL_ONES, ALL_ONES, 32'h0000_4000);
    send_request(ACT_CLEAR, 32'sd0, 32'sd0, 16'd0);
    send_request(ACT_COMPUTE, 32'sd0, 32'sd0, 16'h1000);
    send_request(ACT_COMPUTE, 32'sd0, -32'sh0001_0000, 16'h1000);
    send_request(ACT_COMPUTE, 32'sd0, 32'sh0003_0000, 16'h0100);
    send_request(ACT_COMPUTE, 32'sd0, Q_MAX, 16'd0);      // must not touch the state
    send_request(ACT_COMPUTE, 32'sd0, 32'sh0002_0000, 16'h0100);
    wait_idle();
    load_settings(32'h0, 32'h0, 32'h0001_0000, ALL_ONES, ALL_ONES, 32'h0001_FFFF);
    send_request(ACT_COMPUTE, 32'sd0, Q_MIN, 16'd1);      // rate saturates
    wait_idle();
    load_settings(32'h0, 32'h0, 32'h0001_0000, ALL_ONES, ALL_ONES, 32'h0);
    send_request(ACT_COMPUTE, 32'sd0, Q_MAX, 16'd1);      // filter frozen
  endtask

  // spare indexes ignored, then full-scale gains against zero limits
  task automatic test_register_extremes();
    wait_idle();
    write_reg(CFG_SPARE_6, ALL_ONES);
    write_reg(CFG_SPARE_7, 32'h0);
    release_cfg();
    send_request(ACT_COMPUTE, 32'sh0001_0000, 32'sd0, 16'h4000);
    wait_idle();
    load_settings(ALL_ONES, ALL_ONES, ALL_ONES, 32'h0, 32'h0, 32'h0001_FFFF);
    send_request(ACT_COMPUTE, 32'sh0000_0100, 32'sd0, 16'h0010);
    send_request(ACT_COMPUTE, -32'sh0000_0100, 32'sh0000_0200, 16'h0010);
  endtask

  // receiver holds off for a long stretch while requests keep being offered
  task automatic test_output_stall();
    int unsigned k;
    wait_idle();
    load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0010_0000,
                  32'h0008_0000, 32'h0000_8000);
    rx_hold_cycles = STALL_CYCLES;
    for (k = 0; k < 8; k++) begin
      send_request(ACT_COMPUTE, rand_span(32'h0004_0000), rand_span(32'h0004_0000),
                   16'($urandom_range(16'h0100, 16'h2000)));
    end
  endtask

  task automatic random_settings(int unsigned flavor);
    case (flavor % 4)
      0: load_settings($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                       $urandom_range(0, 32'h0002_0000), $urandom_range(32'h1_0000, 32'h80_0000),
                       $urandom_range(32'h8000, 32'h100_0000), $urandom_range(0, 32'(UNITY)));
      1: load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      2: load_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 32'h0001_FFFF);
      default: load_settings($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                             $urandom_range(0, 32'h0002_0000), 32'h0, 32'h0, 32'h0);
    endcase
  endtask

  // closed-loop-like sequences with random content, plus clears, zero dt and noise
  task automatic test_random_loops();
    int unsigned        ph, mag, r;
    logic signed [31:0] target, plant;
    logic [15:0]        dt;
    longint             step;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      random_settings(ph);
      // a couple of phases run without bubbles on either side
      bubbles_on = (ph % 5 != 2);
      case ($urandom_range(0, 3))
        0:       mag = 32'h0000_0100;
        1:       mag = 32'h0001_0000;
        2:       mag = 32'h0100_0000;
        default: mag = 32'h4000_0000;
      endcase
      target = rand_span(mag);
      plant  = rand_span(mag);
      repeat (ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_request(ACT_CLEAR, rand_span(mag), rand_span(mag), 16'($urandom));
        end else if (r < 8) begin
          send_request(ACT_COMPUTE, target, plant, 16'd0);
        end else if (r < 16) begin
          send_request(act_e'($urandom_range(0, 1)), $urandom, $urandom, 16'($urandom));
        end else begin
          if ($urandom_range(0, 24) == 0) target = rand_span(mag);
          // plant creeps toward the setpoint with some jitter
          step  = (longint'(target) - longint'(plant)) / 8 + longint'(rand_span(mag / 64 + 1));
          plant = clip_s32(longint'(plant) + step);
          dt    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, DT_MAX))
                                              : 16'($urandom_range(16'h0100, 16'h2000));
          send_request(ACT_COMPUTE, target, plant, dt);
        end
      end
    end
    bubbles_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // result taker: random ready, plus the long hold-off when a test asks for it
  initial begin : result_taker
    int unsigned stall;
    rsp_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk_i);
        if (bubbles_on && $urandom_range(0, 3) == 0) begin
          stall = pick_gap();
          if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clk_i);
          end
        end
      end
    end
  end

  // each accepted result against the oldest outstanding prediction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_drives.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_drives.pop_front();
        if (rsp_bus.drive !== want.drive)
          report_mismatch($sformatf("drive %h, expected %h", rsp_bus.drive, want.drive));
        if (rsp_bus.saturation !== want.sat)
          report_mismatch($sformatf("saturation %0d, expected %0d", rsp_bus.saturation,
                                    want.sat));
        n_checked++;
        if (want.sat == SAT_HIGH) n_clip_high++;
        if (want.sat == SAT_LOW) n_clip_low++;
      end
    end
  end

  // watchdog: too long with nothing moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.action      = ACT_COMPUTE;
    req_bus.setpoint    = '0;
    req_bus.measurement = '0;
    req_bus.time_step   = '0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_GAIN_P;
    cfg_data            = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_integral_windup();
    test_derivative_filter();
    test_register_extremes();
    test_output_stall();
    test_random_loops();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d requests (%0d clears, %0d zero time steps) across %0d register sets",
             n_sent, n_clears, n_zero_dt, n_settings);
    $display("run: %0d results checked, %0d clipped high, %0d clipped low, %0d mismatches",
             n_checked, n_clip_high, n_clip_low, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- pid_antiwindup_filtered_derivative.f -----
hw/rtl/pidaw_pkg.sv
hw/rtl/pidaw_req_if.sv
hw/rtl/pidaw_rsp_if.sv
hw/rtl/pid_antiwindup_filtered_derivative.sv
dv/testbench.sv
